### sv/drr_pkg.sv
// ----------------------------------------------------------------------------
// drr_pkg
// Shared types and constants for the DMX512 / RDM frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package drr_pkg;

  // Longest DMX frame in positions, start code included
  localparam int FRAME_SLOTS = 512;

  // Position counter must hold FRAME_SLOTS and any RDM position (below 256)
  localparam int POS_RAW_W = $clog2(FRAME_SLOTS + 1);
  localparam int POS_W     = (POS_RAW_W > 8) ? POS_RAW_W : 8;
  // Window end (start + count) reaches 766, so compare in at least 10 bits
  localparam int CMP_W     = (POS_W > 10) ? POS_W : 10;

  localparam int WSTART_W   = 9;
  localparam int WCOUNT_W   = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int IDX_W      = 9;
  localparam int BYTE_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_COUNT = 1'b1;

  localparam logic [BYTE_W-1:0] START_CODE_DMX = 8'h00;
  localparam logic [BYTE_W-1:0] START_CODE_RDM = 8'hCC;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_ARM  = 1'b1;

  localparam logic PKT_DMX = 1'b0;
  localparam logic PKT_RDM = 1'b1;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_ARMED,
    MODE_DMX,
    MODE_RDM
  } rx_mode_t;

  // Input stage contents handed to the engine
  typedef struct packed {
    logic              valid;
    logic              action;
    logic [BYTE_W-1:0] rx_byte;
  } in_stage_t;

  typedef struct packed {
    logic              packet_type;
    logic [IDX_W-1:0]  slot_index;
    logic [BYTE_W-1:0] slot_value;
    logic              slot_valid;
    logic              packet_end;
    logic              frame_error;
  } out_item_t;

  // Engine result for one transaction: valid is low when nothing is reported
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

endpackage

`default_nettype wire

### sv/drr_in_if.sv
// ----------------------------------------------------------------------------
// drr_in_if
// Received-byte channel: valid/ready handshake with action and byte payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface drr_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

`default_nettype wire

### sv/drr_out_if.sv
// ----------------------------------------------------------------------------
// drr_out_if
// Result channel: valid/ready handshake with one result (slot, end or error) per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface drr_out_if;
  logic       valid;
  logic       ready;
  logic       packet_type;
  logic [8:0] slot_index;
  logic [7:0] slot_value;
  logic       slot_valid;
  logic       packet_end;
  logic       frame_error;

  modport source (output valid, output packet_type, output slot_index,
                  output slot_value, output slot_valid, output packet_end,
                  output frame_error, input ready);
  modport sink   (input valid, input packet_type, input slot_index,
                  input slot_value, input slot_valid, input packet_end,
                  input frame_error, output ready);
endinterface

`default_nettype wire

### sv/drr_in_stage.sv
// ----------------------------------------------------------------------------
// drr_in_stage
// Input register: captures one received transaction and holds it for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module drr_in_stage
  import drr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  drr_in_if.sink     in_chan,
  input  wire logic  advance,
  output in_stage_t  stage
);

  logic              valid_r, valid_nxt;
  logic              action_r;
  logic [BYTE_W-1:0] byte_r;
  logic              take;

  // Stage frees up whenever the engine consumes its content this cycle
  assign in_chan.ready = !valid_r || advance;
  assign take          = in_chan.valid && in_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      action_r <= in_chan.action;
      byte_r   <= in_chan.rx_byte;
    end
  end

  assign stage.valid   = valid_r;
  assign stage.action  = action_r;
  assign stage.rx_byte = byte_r;

endmodule

`default_nettype wire

### sv/drr_engine.sv
// ----------------------------------------------------------------------------
// drr_engine
// Receive state machine: tracks packet mode, position and RDM length, and
// decides the result for each transaction leaving the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module drr_engine
  import drr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  in_stage_t                stage,
  input  wire logic                advance,
  input  wire logic [WSTART_W-1:0] window_start,
  input  wire logic [WCOUNT_W-1:0] window_count,
  output result_t                  result
);

  rx_mode_t          mode_r, mode_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] len_r, len_nxt;

  logic [POS_W-1:0]  pos_inc;
  logic [CMP_W-1:0]  limit;
  logic              in_win;
  logic              done;
  logic              fire;

  assign fire    = stage.valid && advance;
  assign pos_inc = pos_r + POS_W'(1);
  assign limit   = CMP_W'(window_start) + CMP_W'(window_count);
  assign in_win  = (CMP_W'(pos_r) >= CMP_W'(window_start)) && (CMP_W'(pos_r) < limit);
  assign done    = CMP_W'(pos_inc) >= limit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      pos_r  <= '0;
      len_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      len_r  <= len_nxt;
    end
  end

  always_comb begin
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    len_nxt  = len_r;
    result   = '0;
    if (fire) begin
      if (stage.action == ACT_ARM) begin
        // Arm only outside a packet
        if (mode_r == MODE_IDLE || mode_r == MODE_ARMED) begin
          mode_nxt = MODE_ARMED;
          pos_nxt  = '0;
        end
      end else begin
        unique case (mode_r)
          MODE_IDLE: begin
            // drop the byte
          end
          MODE_ARMED: begin
            priority if (stage.rx_byte == START_CODE_RDM) begin
              mode_nxt                = MODE_RDM;
              len_nxt                 = '0;
              pos_nxt                 = POS_W'(1);
              result.valid            = 1'b1;
              result.item.packet_type = PKT_RDM;
              result.item.slot_value  = stage.rx_byte;
              result.item.slot_valid  = 1'b1;
            end else if (stage.rx_byte == START_CODE_DMX) begin
              mode_nxt                = MODE_DMX;
              pos_nxt                 = POS_W'(1);
              result.valid            = 1'b1;
              result.item.packet_type = PKT_DMX;
              result.item.slot_value  = stage.rx_byte;
              result.item.slot_valid  = 1'b1;
            end else begin
              // unknown start code: stay armed
            end
          end
          MODE_DMX: begin
            if (pos_r >= POS_W'(FRAME_SLOTS)) begin
              mode_nxt                = MODE_IDLE;
              pos_nxt                 = '0;
              result.valid            = 1'b1;
              result.item.frame_error = 1'b1;
            end else begin
              pos_nxt = pos_inc;
              if (done) begin
                mode_nxt = MODE_IDLE;
                pos_nxt  = '0;
              end
              result.valid            = in_win || done;
              result.item.packet_type = PKT_DMX;
              result.item.slot_index  = IDX_W'(pos_r);
              result.item.slot_value  = in_win ? stage.rx_byte : '0;
              result.item.slot_valid  = in_win;
              result.item.packet_end  = done;
            end
          end
          MODE_RDM: begin
            priority if (pos_r == POS_W'(1)) begin
              len_nxt                 = stage.rx_byte;
              pos_nxt                 = POS_W'(2);
              result.valid            = 1'b1;
              result.item.packet_type = PKT_RDM;
              result.item.slot_index  = IDX_W'(1);
              result.item.slot_value  = stage.rx_byte;
              result.item.slot_valid  = 1'b1;
            end else if (pos_r < POS_W'(len_r)) begin
              pos_nxt                 = pos_inc;
              result.valid            = 1'b1;
              result.item.packet_type = PKT_RDM;
              result.item.slot_index  = IDX_W'(pos_r);
              result.item.slot_value  = stage.rx_byte;
              result.item.slot_valid  = 1'b1;
            end else begin
              // closing byte is not kept; report the length instead
              mode_nxt                = MODE_IDLE;
              pos_nxt                 = '0;
              result.valid            = 1'b1;
              result.item.packet_type = PKT_RDM;
              result.item.slot_index  = IDX_W'(len_r);
              result.item.packet_end  = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

### sv/drr_out_stage.sv
// ----------------------------------------------------------------------------
// drr_out_stage
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module drr_out_stage
  import drr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  result_t    result,
  output logic       advance,
  drr_out_if.source  out_chan
);

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  // Register may load when empty or when its content leaves this cycle
  assign advance = !valid_r || out_chan.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      item_r <= result.item;
    end
  end

  assign out_chan.valid       = valid_r;
  assign out_chan.packet_type = item_r.packet_type;
  assign out_chan.slot_index  = item_r.slot_index;
  assign out_chan.slot_value  = item_r.slot_value;
  assign out_chan.slot_valid  = item_r.slot_valid;
  assign out_chan.packet_end  = item_r.packet_end;
  assign out_chan.frame_error = item_r.frame_error;

endmodule

`default_nettype wire

### sv/dmx_rdm_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// dmx_rdm_frame_receiver_unit
// DMX512 / RDM receiver: turns a stream of received bytes into slot results.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one transaction per received byte (action 0) or per break
//   (action 1, arm). out_chan returns at most one result per input
//   transaction: the DMX start code and window slots, RDM bytes, a packet end
//   marker, or a frame error on DMX overrun.
//   cfg_we/cfg_index/cfg_data write window_start (index 0) and window_count
//   (index 1); write them only while no packet is being received.
//   Path: the input register captures an accepted transaction; the result
//   register captures its result when it is empty or its content is taken.
//   Throughput: one transaction per cycle while out_chan takes results; the
//   decode is a single pass from the input register into the result register.
//   Stall: while out_chan holds a result that is not taken, the input
//   register accepts one more transaction if empty, then in_chan.ready drops.
//   Reset: rst_n (synchronous, active low) returns the receiver to idle,
//   empties both registers and sets both window registers to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module dmx_rdm_frame_receiver_unit
  import drr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  drr_in_if.sink                     in_chan,
  drr_out_if.source                  out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [WSTART_W-1:0] wstart_r;
  logic [WCOUNT_W-1:0] wcount_r;
  in_stage_t           stage;
  result_t             result;
  logic                advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wstart_r <= WSTART_W'(1);
      wcount_r <= WCOUNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_START: wstart_r <= cfg_data[WSTART_W-1:0];
        CFG_WINDOW_COUNT: wcount_r <= cfg_data[WCOUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  drr_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .advance (advance),
    .stage   (stage)
  );

  drr_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .stage        (stage),
    .advance      (advance),
    .window_start (wstart_r),
    .window_count (wcount_r),
    .result       (result)
  );

  drr_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .result   (result),
    .advance  (advance),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

### sv/drr_checker.sv
// ----------------------------------------------------------------------------
// drr_checker
// Port-level checks on the receiver's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module drr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       packet_type,
  input wire logic [8:0] slot_index,
  input wire logic [7:0] slot_value,
  input wire logic       slot_valid,
  input wire logic       packet_end,
  input wire logic       frame_error
);

  // Hold a stalled result: valid, index, value, slot_valid and end flag stay
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(slot_index)
      && $stable(slot_value) && $stable(slot_valid) && $stable(packet_end))
    else $error("stalled result changed");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present right after reset");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && frame_error |-> !slot_valid && !packet_end && !packet_type
      && slot_index == 9'd0 && slot_value == 8'd0)
    else $error("frame error carries slot data");

  a_rdm_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && packet_type && packet_end |-> !slot_valid && !frame_error)
    else $error("RDM end carries a captured byte");

  a_empty_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !slot_valid |-> slot_value == 8'd0 && (packet_end || frame_error))
    else $error("result without slot is neither end nor error");

endmodule

bind dmx_rdm_frame_receiver_unit drr_checker u_drr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .packet_type (out_chan.packet_type),
  .slot_index  (out_chan.slot_index),
  .slot_value  (out_chan.slot_value),
  .slot_valid  (out_chan.slot_valid),
  .packet_end  (out_chan.packet_end),
  .frame_error (out_chan.frame_error)
);

`default_nettype wire

### test/dmx_rdm_frame_receiver_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmx_rdm_frame_receiver_unit_tb
// Self-checking bench for the DMX512 / RDM frame receiver. A directed table
// walks the start codes, the arm and idle cases, short RDM packets and DMX
// windows. Random packets follow under several window settings, extremes
// included. Typed table rows give their own expected result; all other results
// are compared with a cycle-free model of the receiver. Both channels idle at
// random, and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------

module dmx_rdm_frame_receiver_unit_tb;
  import drr_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int TIMEOUT_CYCLES = 400000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int HOLD_CYCLES    = 120;
  localparam int HOLD_AFTER     = 40;
  localparam int N_PHASES       = 7;

  typedef struct {
    logic       act;
    logic [7:0] data;
    bit         typed;
    bit         has;
    out_item_t  want;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  drr_in_if  in_chan ();
  drr_out_if out_chan ();

  dmx_rdm_frame_receiver_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Receiver model state
  rx_mode_t    rcv_mode  = MODE_IDLE;
  logic [9:0]  slot_pos  = '0;
  logic [7:0]  rdm_len   = '0;
  logic [8:0]  win_first = 9'd1;
  logic [7:0]  win_span  = 8'd1;

  out_item_t   pending_slots[$];

  int unsigned fail_count  = 0;
  int unsigned n_items     = 0;
  int unsigned live_items  = 0;
  int unsigned n_results   = 0;
  int unsigned n_ends      = 0;
  int unsigned n_overruns  = 0;
  bit          src_calm    = 1'b0;
  bit          snk_calm    = 1'b0;
  bit          held        = 1'b0;

  int unsigned ph_first[N_PHASES] = '{3, 511, 1, 2, 7, 1, 5};
  int unsigned ph_span[N_PHASES]  = '{4, 255, 255, 10, 1, 1, 30};
  // zero: one full-length DMX frame instead of random packets
  int unsigned ph_items[N_PHASES] = '{120, 0, 140, 110, 100, 100, 100};

  always begin
    clk = 1'b0;
    #(CLK_PERIOD / 2);
    clk = 1'b1;
    #(CLK_PERIOD / 2);
  end

  function automatic out_item_t slot_item(logic pkt, logic [8:0] idx, logic [7:0] val,
                                          logic vld, logic fin, logic err);
    out_item_t it;
    it.packet_type = pkt;
    it.slot_index  = idx;
    it.slot_value  = val;
    it.slot_valid  = vld;
    it.packet_end  = fin;
    it.frame_error = err;
    return it;
  endfunction

  // Advance the receiver model by one transaction; valid marks a result.
  function automatic result_t next_slot(logic act, logic [7:0] b);
    result_t    r;
    logic [9:0] p;
    logic [9:0] lim;
    bit         in_win;
    bit         done;
    r = '0;
    p = slot_pos;
    if (act == ACT_ARM) begin
      if (rcv_mode == MODE_IDLE || rcv_mode == MODE_ARMED) begin
        rcv_mode = MODE_ARMED;
        slot_pos = '0;
      end
      return r;
    end
    case (rcv_mode)
      MODE_IDLE: begin
      end
      MODE_ARMED: begin
        if (b == START_CODE_RDM) begin
          rcv_mode = MODE_RDM;
          rdm_len  = '0;
          slot_pos = 10'd1;
          r.valid  = 1'b1;
          r.item   = slot_item(PKT_RDM, 9'd0, b, 1'b1, 1'b0, 1'b0);
        end else if (b == START_CODE_DMX) begin
          rcv_mode = MODE_DMX;
          slot_pos = 10'd1;
          r.valid  = 1'b1;
          r.item   = slot_item(PKT_DMX, 9'd0, b, 1'b1, 1'b0, 1'b0);
        end
      end
      MODE_DMX: begin
        lim    = 10'(win_first) + 10'(win_span);
        in_win = (p >= win_first) && (p < lim);
        if (p >= FRAME_SLOTS) begin
          rcv_mode = MODE_IDLE;
          slot_pos = '0;
          r.valid  = 1'b1;
          r.item   = slot_item(PKT_DMX, 9'd0, 8'h00, 1'b0, 1'b0, 1'b1);
        end else begin
          slot_pos = p + 10'd1;
          done     = (slot_pos >= lim);
          if (done) begin
            rcv_mode = MODE_IDLE;
            slot_pos = '0;
          end
          if (in_win || done) begin
            r.valid = 1'b1;
            r.item  = slot_item(PKT_DMX, p[8:0], in_win ? b : 8'h00, in_win, done, 1'b0);
          end
        end
      end
      MODE_RDM: begin
        r.valid = 1'b1;
        if (p == 10'd1) begin
          rdm_len  = b;
          slot_pos = 10'd2;
          r.item   = slot_item(PKT_RDM, 9'd1, b, 1'b1, 1'b0, 1'b0);
        end else if (p < rdm_len) begin
          slot_pos = p + 10'd1;
          r.item   = slot_item(PKT_RDM, p[8:0], b, 1'b1, 1'b0, 1'b0);
        end else begin
          rcv_mode = MODE_IDLE;
          slot_pos = '0;
          r.item   = slot_item(PKT_RDM, {1'b0, rdm_len}, 8'h00, 1'b0, 1'b1, 1'b0);
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Offer one transaction; on acceptance, queue the slot the receiver owes.
  task automatic send_item(input logic act, input logic [7:0] data, input bit typed = 1'b0,
                           input bit typed_has = 1'b0, input out_item_t typed_item = '0);
    int unsigned gap;
    bit          ignored;
    result_t     pred;
    if (n_items % 64 == 0) src_calm = ($urandom_range(0, 3) == 0);
    gap = src_calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.action  <= act;
    in_chan.rx_byte <= data;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    ignored = (act == ACT_BYTE && rcv_mode == MODE_IDLE) ||
              (act == ACT_ARM && (rcv_mode == MODE_DMX || rcv_mode == MODE_RDM)) ||
              (act == ACT_BYTE && rcv_mode == MODE_ARMED &&
               data != START_CODE_DMX && data != START_CODE_RDM);
    if (!ignored) live_items++;
    n_items++;
    pred = next_slot(act, data);
    if (typed) begin
      if (typed_has) pending_slots.push_back(typed_item);
    end else if (pred.valid) begin
      pending_slots.push_back(pred.item);
    end
  endtask

  task automatic random_packet();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      // noise: loose arms and bytes
      repeat ($urandom_range(1, 4))
        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end else begin
      send_item(ACT_ARM, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0) send_item(ACT_BYTE, 8'($urandom_range(1, 255)));
      send_item(ACT_BYTE, (kind < 6) ? START_CODE_DMX : START_CODE_RDM);
      if (rcv_mode == MODE_RDM)
        send_item(ACT_BYTE, ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                        : 8'($urandom_range(0, 12)));
      while (rcv_mode == MODE_DMX || rcv_mode == MODE_RDM)
        send_item(($urandom_range(0, 24) == 0) ? ACT_ARM : ACT_BYTE,
                  8'($urandom_range(0, 255)));
    end
  endtask

  // Close any open packet, drop valid, and drain all results.
  task automatic finish_phase();
    while (rcv_mode == MODE_DMX || rcv_mode == MODE_RDM)
      send_item(ACT_BYTE, 8'($urandom_range(0, 255)));
    in_chan.valid <= 1'b0;
    while (pending_slots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input logic [8:0] first, input logic [7:0] span);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WINDOW_START;
    cfg_data  <= first;
    @(posedge clk);
    cfg_index <= CFG_WINDOW_COUNT;
    cfg_data  <= {1'b0, span};
    @(posedge clk);
    cfg_we    <= 1'b0;
    win_first = first;
    win_span  = span;
  endtask

  task automatic check_slot();
    out_item_t want;
    if (pending_slots.size() == 0) begin
      $error("unexpected result: slot_index %0d slot_value 0x%02h",
             out_chan.slot_index, out_chan.slot_value);
      fail_count++;
      return;
    end
    want = pending_slots.pop_front();
    if (out_chan.packet_type !== want.packet_type) begin
      $error("packet_type: expected %0d, got %0d", want.packet_type, out_chan.packet_type);
      fail_count++;
    end
    if (out_chan.slot_index !== want.slot_index) begin
      $error("slot_index: expected %0d, got %0d", want.slot_index, out_chan.slot_index);
      fail_count++;
    end
    if (out_chan.slot_value !== want.slot_value) begin
      $error("slot_value: expected 0x%02h, got 0x%02h", want.slot_value, out_chan.slot_value);
      fail_count++;
    end
    if (out_chan.slot_valid !== want.slot_valid) begin
      $error("slot_valid: expected %0d, got %0d", want.slot_valid, out_chan.slot_valid);
      fail_count++;
    end
    if (out_chan.packet_end !== want.packet_end) begin
      $error("packet_end: expected %0d, got %0d", want.packet_end, out_chan.packet_end);
      fail_count++;
    end
    if (out_chan.frame_error !== want.frame_error) begin
      $error("frame_error: expected %0d, got %0d", want.frame_error, out_chan.frame_error);
      fail_count++;
    end
    if (out_chan.packet_end === 1'b1) n_ends++;
    if (out_chan.frame_error === 1'b1) n_overruns++;
  endtask

  // Result side: random stalls, calm stretches, and one long hold-off
  initial begin
    int unsigned gap;
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held && n_results >= HOLD_AFTER) begin
        held = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (n_results % 50 == 0) snk_calm = ($urandom_range(0, 3) == 0);
      gap = snk_calm ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
        out_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (out_chan.valid !== 1'b1);
      check_slot();
      n_results++;
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timeout: %0d results still outstanding", pending_slots.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    int        ph;
    rst_n           = 1'b0;
    in_chan.valid   = 1'b0;
    in_chan.action  = ACT_BYTE;
    in_chan.rx_byte = 8'h00;
    cfg_we          = 1'b0;
    cfg_index       = CFG_WINDOW_START;
    cfg_data        = '0;

    // Window after reset is slot 1 only
    rows.push_back('{ACT_BYTE, 8'h55, 1, 0, '0});      // byte while idle
    rows.push_back('{ACT_ARM,  8'h00, 1, 0, '0});
    rows.push_back('{ACT_BYTE, 8'h55, 1, 0, '0});      // unknown start code
    rows.push_back('{ACT_ARM,  8'hFF, 1, 0, '0});      // re-arm while armed
    rows.push_back('{ACT_BYTE, START_CODE_DMX, 1, 1,
                     slot_item(PKT_DMX, 9'd0, 8'h00, 1'b1, 1'b0, 1'b0)});
    rows.push_back('{ACT_ARM,  8'h00, 1, 0, '0});      // arm inside a frame
    rows.push_back('{ACT_BYTE, 8'hFF, 1, 1,
                     slot_item(PKT_DMX, 9'd1, 8'hFF, 1'b1, 1'b1, 1'b0)});
    rows.push_back('{ACT_BYTE, 8'h12, 1, 0, '0});
    rows.push_back('{ACT_ARM,  8'h00, 1, 0, '0});
    rows.push_back('{ACT_BYTE, START_CODE_RDM, 1, 1,
                     slot_item(PKT_RDM, 9'd0, 8'hCC, 1'b1, 1'b0, 1'b0)});
    rows.push_back('{ACT_BYTE, 8'h00, 1, 1,
                     slot_item(PKT_RDM, 9'd1, 8'h00, 1'b1, 1'b0, 1'b0)});
    rows.push_back('{ACT_ARM,  8'h00, 1, 0, '0});      // arm inside a packet
    rows.push_back('{ACT_BYTE, 8'hAB, 1, 1,
                     slot_item(PKT_RDM, 9'd0, 8'h00, 1'b0, 1'b1, 1'b0)});
    rows.push_back('{ACT_ARM,  8'h00, 1, 0, '0});
    rows.push_back('{ACT_BYTE, START_CODE_RDM, 0, 0, '0});
    rows.push_back('{ACT_BYTE, 8'h04, 1, 1,
                     slot_item(PKT_RDM, 9'd1, 8'h04, 1'b1, 1'b0, 1'b0)});
    rows.push_back('{ACT_BYTE, 8'hA5, 0, 0, '0});
    rows.push_back('{ACT_BYTE, 8'h5A, 0, 0, '0});
    rows.push_back('{ACT_BYTE, 8'h77, 0, 0, '0});
    rows.push_back('{ACT_ARM,  8'h00, 1, 0, '0});
    rows.push_back('{ACT_BYTE, START_CODE_RDM, 0, 0, '0});
    rows.push_back('{ACT_BYTE, 8'h01, 1, 1,
                     slot_item(PKT_RDM, 9'd1, 8'h01, 1'b1, 1'b0, 1'b0)});
    rows.push_back('{ACT_BYTE, 8'h33, 1, 1,
                     slot_item(PKT_RDM, 9'd1, 8'h00, 1'b0, 1'b1, 1'b0)});
    rows.push_back('{ACT_ARM,  8'h00, 0, 0, '0});
    rows.push_back('{ACT_BYTE, START_CODE_DMX, 0, 0, '0});
    rows.push_back('{ACT_BYTE, 8'h80, 0, 0, '0});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (rows[i])
      send_item(rows[i].act, rows[i].data, rows[i].typed, rows[i].has, rows[i].want);

    for (ph = 0; ph < N_PHASES; ph++) begin
      finish_phase();
      set_window(9'(ph_first[ph]), 8'(ph_span[ph]));
      live_items = 0;
      if (ph_items[ph] == 0) begin
        // run a full frame out to the overrun
        send_item(ACT_ARM, 8'($urandom_range(0, 255)));
        send_item(ACT_BYTE, START_CODE_DMX);
        while (rcv_mode == MODE_DMX) send_item(ACT_BYTE, 8'($urandom_range(0, 255)));
      end else begin
        while (live_items < ph_items[ph]) random_packet();
      end
    end
    finish_phase();

    $display("Run covered %0d transactions and %0d results over %0d window settings",
             n_items, n_results, N_PHASES + 1);
    $display("Packets ended: %0d, DMX overruns: %0d, mismatches: %0d",
             n_ends, n_overruns, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### dmx_rdm_frame_receiver_unit.f
sv/drr_pkg.sv
sv/drr_in_if.sv
sv/drr_out_if.sv
sv/drr_in_stage.sv
sv/drr_engine.sv
sv/drr_out_stage.sv
sv/dmx_rdm_frame_receiver_unit.sv
sv/drr_checker.sv
test/dmx_rdm_frame_receiver_unit_tb.sv
